FILE: rtl/rrs_pkg.sv
// Shared types and constants for the round-robin time-slice scheduler.
// No dependencies; used by every module in rtl/.
package rrs_pkg;

   localparam int DEFAULT_MAX_PROCS = 16;
   localparam logic [7:0] QUANTUM_RESET = 8'd4;
   localparam int TIME_W = 32;
   localparam int SUM_W = 40;
   localparam int BURST_W = 16;
   localparam int PID_W = 4;
   localparam int RSP_DATA_W = 112;

   typedef enum logic [1:0] {
      KIND_ACCEPT   = 2'd0,
      KIND_REJECT   = 2'd1,
      KIND_DISPATCH = 2'd2,
      KIND_DONE     = 2'd3
   } kind_type;

   typedef enum logic {
      MODE_ARRIVAL = 1'b0,
      MODE_TICK    = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [BURST_W-1:0]  burst_time;
   } item_type;

   typedef struct packed {
      kind_type            kind;
      logic [TIME_W-1:0]   event_time;
      logic [PID_W-1:0]    process_id;
      logic [TIME_W-1:0]   wait_time;
      logic [SUM_W-1:0]    total_wait;
      logic                last;
   } result_type;

endpackage

FILE: rtl/rrs_front.sv
// Front end: accepts the items that the top level builds from request transfers.
// Holds them in a two-entry queue for the scheduler core. Uses rrs_pkg.
module rrs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rrs_pkg::item_type in_item,
   output logic              item_valid,
   input  logic              item_take,
   output rrs_pkg::item_type item
);

   rrs_pkg::item_type slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push, pop;
   logic              wr_ptr_in, rd_ptr_in;
   logic [1:0]        count_in;

   assign in_ready   = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = in_valid && in_ready;
   assign pop        = item_valid && item_take;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold payload, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: rtl/rrs_core.sv
// Back end: scheduler state, ready queue, process tables and result queue.
// Executes one item per cycle while its result queue has room for two results. Uses rrs_pkg.
module rrs_core #(
   parameter int MAX_PROCS = rrs_pkg::DEFAULT_MAX_PROCS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [7:0]          csr_wdata,
   input  logic                item_valid,
   output logic                item_take,
   input  rrs_pkg::item_type   item,
   output logic                res_valid,
   input  logic                res_ready,
   output rrs_pkg::result_type res
);

   localparam int IdW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CntW = $clog2(MAX_PROCS + 1);
   localparam int OqDepth = 4;
   localparam int OqPtrW = 2;
   localparam int OqCntW = 3;
   localparam logic [IdW-1:0] LastSlot = IdW'(MAX_PROCS - 1);
   localparam logic [CntW-1:0] ProcLimit = CntW'(MAX_PROCS);
   localparam logic [rrs_pkg::TIME_W-1:0] TimeMax = '1;
   localparam logic [rrs_pkg::SUM_W-1:0] SumMax = '1;

   function automatic logic [IdW-1:0] next_slot(input logic [IdW-1:0] x);
      next_slot = (x == LastSlot) ? '0 : x + 1'b1;
   endfunction

   function automatic logic [rrs_pkg::PID_W-1:0] to_pid(input logic [IdW-1:0] x);
      logic [IdW+rrs_pkg::PID_W-1:0] wide;
      wide   = {{rrs_pkg::PID_W{1'b0}}, x};
      to_pid = wide[rrs_pkg::PID_W-1:0];
   endfunction

   // state
   logic [7:0]                   quantum_ff;
   logic [rrs_pkg::TIME_W-1:0]   time_now_ff, time_now_in;
   logic [IdW-1:0]               ready_fifo_ff [MAX_PROCS];
   logic [IdW-1:0]               head_ff, head_in, tail_ff, tail_in;
   logic [CntW-1:0]              fifo_count_ff, fifo_count_in;
   logic [rrs_pkg::BURST_W-1:0]  remaining_ff [MAX_PROCS];
   logic [rrs_pkg::TIME_W-1:0]   arrival_ff [MAX_PROCS];
   logic [rrs_pkg::BURST_W-1:0]  burst_ff [MAX_PROCS];
   logic [IdW-1:0]               running_id_ff, running_id_in;
   logic                         running_valid_ff, running_valid_in;
   logic [7:0]                   slice_used_ff, slice_used_in;
   logic                         requeue_ff, requeue_in;
   logic [CntW-1:0]              proc_count_ff, proc_count_in;
   logic [rrs_pkg::SUM_W-1:0]    wait_sum_ff, wait_sum_in;

   // result queue
   rrs_pkg::result_type          oq_ff [OqDepth];
   logic [OqPtrW-1:0]            oq_wp_ff, oq_wp_in, oq_rp_ff, oq_rp_in;
   logic [OqCntW-1:0]            oq_count_ff, oq_count_in;

   // datapath
   logic                         arrival, tick, accept, rq, disp, run, done, preempt;
   logic [IdW-1:0]               new_id, pop_id, cur_id;
   logic [CntW-1:0]              cnt_a;
   logic [rrs_pkg::BURST_W-1:0]  rem, rem_n;
   logic [7:0]                   slice_base, slice_n;
   logic [rrs_pkg::TIME_W:0]     spent;
   logic [rrs_pkg::TIME_W-1:0]   wait_n;
   logic [rrs_pkg::SUM_W:0]      sum_wide;
   logic                         fifo_wr;
   logic [IdW-1:0]               fifo_wr_id;
   logic [1:0]                   n_res;
   rrs_pkg::result_type          r0, r1;
   logic                         oq_pop;

   assign item_take = item_valid && (oq_count_ff <= OqCntW'(OqDepth - 2));
   assign arrival   = item_take && (item.mode == rrs_pkg::MODE_ARRIVAL);
   assign tick      = item_take && (item.mode == rrs_pkg::MODE_TICK);
   assign accept    = arrival && (item.burst_time != '0) && (proc_count_ff < ProcLimit);
   assign new_id    = proc_count_ff[IdW-1:0];

   assign res_valid = (oq_count_ff != '0);
   assign res       = oq_ff[oq_rp_ff];
   assign oq_pop    = res_valid && res_ready;

   always_comb begin
      rq         = !running_valid_ff && requeue_ff;
      cnt_a      = fifo_count_ff + {{(CntW-1){1'b0}}, rq};
      disp       = !running_valid_ff && (cnt_a != '0);
      pop_id     = (fifo_count_ff == '0) ? running_id_ff : ready_fifo_ff[head_ff];
      cur_id     = disp ? pop_id : running_id_ff;
      run        = running_valid_ff || disp;
      rem        = remaining_ff[cur_id];
      rem_n      = (rem != '0) ? rem - 1'b1 : rem;
      slice_base = disp ? 8'd0 : slice_used_ff;
      slice_n    = (slice_base != 8'hFF) ? slice_base + 8'd1 : slice_base;
      time_now_in = time_now_ff;
      if (tick && time_now_ff != TimeMax) begin
         time_now_in = time_now_ff + 1'b1;
      end
      done       = run && (rem_n == '0);
      preempt    = run && !done && (slice_n >= quantum_ff);
      spent      = {1'b0, arrival_ff[cur_id]}
                 + {{(rrs_pkg::TIME_W-rrs_pkg::BURST_W+1){1'b0}}, burst_ff[cur_id]};
      wait_n     = ({1'b0, time_now_in} > spent)
                 ? time_now_in - spent[rrs_pkg::TIME_W-1:0] : '0;
      sum_wide   = {1'b0, wait_sum_ff}
                 + {{(rrs_pkg::SUM_W-rrs_pkg::TIME_W+1){1'b0}}, wait_n};

      head_in          = head_ff;
      tail_in          = tail_ff;
      fifo_count_in    = fifo_count_ff;
      running_id_in    = running_id_ff;
      running_valid_in = running_valid_ff;
      slice_used_in    = slice_used_ff;
      requeue_in       = requeue_ff;
      proc_count_in    = proc_count_ff;
      wait_sum_in      = wait_sum_ff;
      fifo_wr          = 1'b0;
      fifo_wr_id       = new_id;

      if (accept) begin
         fifo_wr       = 1'b1;
         tail_in       = next_slot(tail_ff);
         fifo_count_in = fifo_count_ff + 1'b1;
         proc_count_in = proc_count_ff + 1'b1;
      end
      if (tick) begin
         if (rq) begin
            fifo_wr    = 1'b1;
            fifo_wr_id = running_id_ff;
            tail_in    = next_slot(tail_ff);
            requeue_in = 1'b0;
         end
         fifo_count_in = cnt_a - {{(CntW-1){1'b0}}, disp};
         if (disp) begin
            head_in = next_slot(head_ff);
         end
         running_id_in = cur_id;
         if (run) begin
            slice_used_in    = slice_n;
            running_valid_in = !done && !preempt;
         end
         if (preempt) begin
            requeue_in = 1'b1;
         end
         if (done) begin
            wait_sum_in = sum_wide[rrs_pkg::SUM_W] ? SumMax : sum_wide[rrs_pkg::SUM_W-1:0];
         end
      end
   end

   // build up to two results per item
   always_comb begin
      r0 = '0;
      r1 = '0;
      n_res = 2'd0;
      if (arrival) begin
         r0.kind       = accept ? rrs_pkg::KIND_ACCEPT : rrs_pkg::KIND_REJECT;
         r0.event_time = time_now_ff;
         r0.process_id = accept ? to_pid(new_id) : '0;
         r0.total_wait = wait_sum_ff;
         r0.last       = 1'b1;
         n_res         = 2'd1;
      end else if (tick) begin
         if (disp) begin
            r0.kind       = rrs_pkg::KIND_DISPATCH;
            r0.event_time = time_now_ff;
            r0.process_id = to_pid(cur_id);
            r0.total_wait = wait_sum_ff;
            r0.last       = !done;
         end
         if (done) begin
            r1.kind       = rrs_pkg::KIND_DONE;
            r1.event_time = time_now_in;
            r1.process_id = to_pid(cur_id);
            r1.wait_time  = wait_n;
            r1.total_wait = wait_sum_in;
            r1.last       = 1'b1;
         end
         if (!disp) begin
            r0 = r1;
         end
         n_res = {1'b0, disp} + {1'b0, done};
      end
      oq_wp_in    = oq_wp_ff + OqPtrW'(n_res);
      oq_rp_in    = oq_pop ? oq_rp_ff + 1'b1 : oq_rp_ff;
      oq_count_in = oq_count_ff + OqCntW'(n_res) - {{(OqCntW-1){1'b0}}, oq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff       <= rrs_pkg::QUANTUM_RESET;
         time_now_ff      <= '0;
         head_ff          <= '0;
         tail_ff          <= '0;
         fifo_count_ff    <= '0;
         running_id_ff    <= '0;
         running_valid_ff <= 1'b0;
         slice_used_ff    <= '0;
         requeue_ff       <= 1'b0;
         proc_count_ff    <= '0;
         wait_sum_ff      <= '0;
         oq_wp_ff         <= '0;
         oq_rp_ff         <= '0;
         oq_count_ff      <= '0;
      end else begin
         if (csr_we) begin
            quantum_ff <= csr_wdata;
         end
         time_now_ff      <= time_now_in;
         head_ff          <= head_in;
         tail_ff          <= tail_in;
         fifo_count_ff    <= fifo_count_in;
         running_id_ff    <= running_id_in;
         running_valid_ff <= running_valid_in;
         slice_used_ff    <= slice_used_in;
         requeue_ff       <= requeue_in;
         proc_count_ff    <= proc_count_in;
         wait_sum_ff      <= wait_sum_in;
         oq_wp_ff         <= oq_wp_in;
         oq_rp_ff         <= oq_rp_in;
         oq_count_ff      <= oq_count_in;
      end
   end

   // tables and queues: payload only
   always_ff @(posedge clock) begin
      if (fifo_wr) begin
         ready_fifo_ff[tail_ff] <= fifo_wr_id;
      end
      if (accept) begin
         remaining_ff[new_id] <= item.burst_time;
         burst_ff[new_id]     <= item.burst_time;
         arrival_ff[new_id]   <= time_now_ff;
      end
      if (tick && run) begin
         remaining_ff[cur_id] <= rem_n;
      end
      if (n_res != 2'd0) begin
         oq_ff[oq_wp_ff] <= r0;
      end
      if (n_res == 2'd2) begin
         oq_ff[oq_wp_ff + 1'b1] <= r1;
      end
   end

   a_fifo_le_procs: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= proc_count_ff)
      else $error("ready queue holds more ids than accepted processes");
   a_procs_limit: assert property (@(posedge clock) disable iff (reset)
      proc_count_ff <= ProcLimit)
      else $error("process count beyond table size");
   a_run_xor_requeue: assert property (@(posedge clock) disable iff (reset)
      !(running_valid_ff && requeue_ff))
      else $error("preempted process still marked running");
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_count_ff <= OqCntW'(OqDepth))
      else $error("result queue overflow");

endmodule

FILE: rtl/round_robin_time_slice_scheduler.sv
// Top level of the round-robin time-slice scheduler.
// Instantiates rrs_front and rrs_core; uses rrs_pkg.
//
// The block takes one request transfer per clock cycle, arrivals and ticks
// alike, while the front queue has room, and returns one response transfer per
// cycle while rsp_tready is high. An arrival yields one response; a tick yields
// none, one or two (dispatch, then completion), and rsp_tlast marks the final
// response of each request. Requests wait in the two-entry front queue; the core
// stalls only when its four-entry response queue has fewer than two free slots,
// so a tick that yields two responses can hold the request side while the
// response side drains. A request is registered in the front queue and its
// responses in the response queue.
// Write csr_wdata (time quantum) only while the block is idle.
module round_robin_time_slice_scheduler #(
   parameter int MAX_PROCS = rrs_pkg::DEFAULT_MAX_PROCS
) (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata,   // time_quantum
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [15:0] burst_time
   input  logic         req_tuser,   // [0] mode
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // [31:0] event_time, [35:32] process_id,
                                     // [67:36] wait_time, [107:68] total_wait
   output logic [1:0]   rsp_tuser,   // [1:0] kind
   output logic         rsp_tlast
);

   rrs_pkg::item_type   in_item, item;
   rrs_pkg::result_type res;
   logic                item_valid, item_take;

   // classify the request: tuser carries the mode
   always_comb begin
      in_item.mode       = rrs_pkg::mode_type'(req_tuser);
      in_item.burst_time = req_tdata;
   end

   rrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   rrs_core #(
      .MAX_PROCS (MAX_PROCS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res        (res)
   );

   // pack the response, event_time in the lowest bits, zero fill to bytes
   assign rsp_tdata = {4'b0, res.total_wait, res.wait_time, res.process_id, res.event_time};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for round_robin_time_slice_scheduler.
// Holds its own scheduler predictor and checks every response transfer against it;
// depends on rtl/rrs_pkg.sv and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
   import rrs_pkg::*;

   localparam int PROCS = DEFAULT_MAX_PROCS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [7:0]   csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;    // [15:0] burst_time
   logic         req_tuser = 1'b0;  // [0] mode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;         // [31:0] event_time, [35:32] process_id,
                                    // [67:36] wait_time, [107:68] total_wait
   logic [1:0]   rsp_tuser;         // [1:0] kind
   logic         rsp_tlast;

   round_robin_time_slice_scheduler u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Scheduler predictor state
   // ---------------------------------------------------------------------
   logic [7:0]         quantum;
   logic [31:0]        clock_now;
   logic [PID_W-1:0]   ready_q[$];
   logic [15:0]        left_ticks[PROCS];
   logic [31:0]        arrived_at[PROCS];
   logic [15:0]        burst_len[PROCS];
   logic [PID_W-1:0]   cur_pid;
   logic               cur_busy;
   logic [7:0]         slice_ticks;
   logic               preempted;
   int                 admitted;
   logic [SUM_W-1:0]   wait_total;

   result_type         sched_events[$];  // expected responses, oldest first
   int                 errors = 0;
   int                 cycles = 0;
   bit                 idle_on = 1'b0;   // random gaps and stalls enabled
   bit                 hold_req = 1'b0;
   int                 hold_cnt = 0;
   int                 stall_cnt = 0;

   // Append one expected response.
   function automatic void push_event(kind_type k, logic [31:0] t, logic [PID_W-1:0] pid,
                                      logic [31:0] w);
      result_type r;
      r.kind = k;
      r.event_time = t;
      r.process_id = pid;
      r.wait_time = w;
      r.total_wait = wait_total;
      r.last = 1'b0;
      sched_events = {sched_events, r};
   endfunction

   // Advance the predictor by one request; mark the final response as last.
   function automatic void schedule_step(mode_type m, logic [15:0] b);
      int before_n;
      logic [32:0] spent;
      logic [31:0] w;
      logic [SUM_W:0] sum;
      before_n = sched_events.size();
      if (m == MODE_ARRIVAL) begin
         if (b == 0 || admitted >= PROCS) begin
            push_event(KIND_REJECT, clock_now, '0, '0);
         end else begin
            left_ticks[admitted] = b;
            burst_len[admitted] = b;
            arrived_at[admitted] = clock_now;
            ready_q = {ready_q, PID_W'(admitted)};
            push_event(KIND_ACCEPT, clock_now, PID_W'(admitted), '0);
            admitted++;
         end
      end else begin
         if (!cur_busy) begin
            // Requeue the preempted process behind any arrivals, then dispatch.
            if (preempted) begin
               ready_q = {ready_q, cur_pid};
               preempted = 1'b0;
            end
            if (ready_q.size() > 0) begin
               cur_pid = ready_q.pop_front();
               cur_busy = 1'b1;
               slice_ticks = '0;
               push_event(KIND_DISPATCH, clock_now, cur_pid, '0);
            end
         end
         if (clock_now != '1) clock_now++;
         if (cur_busy) begin
            if (left_ticks[cur_pid] > 0) left_ticks[cur_pid]--;
            if (slice_ticks != 8'hFF) slice_ticks++;
            if (left_ticks[cur_pid] == 0) begin
               spent = {1'b0, arrived_at[cur_pid]} + burst_len[cur_pid];
               w = ({1'b0, clock_now} > spent) ? 32'({1'b0, clock_now} - spent) : '0;
               sum = {1'b0, wait_total} + w;
               wait_total = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
               cur_busy = 1'b0;
               push_event(KIND_DONE, clock_now, cur_pid, w);
            end else if (slice_ticks >= quantum) begin
               cur_busy = 1'b0;
               preempted = 1'b1;
            end
         end
      end
      if (sched_events.size() > before_n)
         sched_events[sched_events.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: stall in random bursts, or hold off for a long stretch
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_req) begin
         hold_cnt = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_cnt > 0) begin
         stall_cnt--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_cnt = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each response transfer with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sched_events.size() == 0) begin
            $display("%0t: unexpected response kind=%0d pid=%0d time=%0d", $time,
                     rsp_tuser, rsp_tdata[35:32], rsp_tdata[31:0]);
            errors++;
         end else begin
            want = sched_events.pop_front();
            if (rsp_tuser !== want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== want.event_time) begin
               $display("%0t: event_time expected %0d actual %0d", $time,
                        want.event_time, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[35:32] !== want.process_id) begin
               $display("%0t: process_id expected %0d actual %0d", $time,
                        want.process_id, rsp_tdata[35:32]);
               errors++;
            end
            if (rsp_tdata[67:36] !== want.wait_time) begin
               $display("%0t: wait_time expected %0d actual %0d", $time,
                        want.wait_time, rsp_tdata[67:36]);
               errors++;
            end
            if (rsp_tdata[107:68] !== want.total_wait) begin
               $display("%0t: total_wait expected %0d actual %0d", $time,
                        want.total_wait, rsp_tdata[107:68]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offer one request and hold it until the transfer; valid stays high after
   // the transfer so back-to-back requests never drop it within one step.
   task automatic send_item(mode_type m, logic [15:0] b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= m;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      schedule_step(m, b);
   endtask

   task automatic run_ticks(int n);
      repeat (n) send_item(MODE_TICK, 16'($urandom));
   endtask

   // Drop valid, wait for every expected response, then let in-flight ticks
   // that produce no response clear the pipeline.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (sched_events.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_quantum(logic [7:0] q);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= q;
      @(posedge clock);
      csr_we <= 1'b0;
      quantum = q;
   endtask

   // Reset quantum: a reject, an idle tick, arrivals queued ahead of a preempted process.
   task automatic test_default_quantum;
      send_item(MODE_ARRIVAL, 16'd0);
      send_item(MODE_TICK, 16'hFFFF);
      send_item(MODE_ARRIVAL, 16'd1);
      send_item(MODE_ARRIVAL, 16'd6);
      run_ticks(5);
      send_item(MODE_ARRIVAL, 16'd2);
      run_ticks(6);
   endtask

   // Quantum 1, 0 and 255: preempt every tick, then run a long slice out.
   task automatic test_quantum_extremes;
      set_quantum(8'd1);
      send_item(MODE_ARRIVAL, 16'd3);
      run_ticks(4);
      set_quantum(8'd0);
      send_item(MODE_ARRIVAL, 16'd2);
      send_item(MODE_ARRIVAL, 16'd2);
      run_ticks(5);
      set_quantum(8'd255);
      send_item(MODE_ARRIVAL, 16'd260);
      send_item(MODE_ARRIVAL, 16'd5);
      run_ticks(270);
   endtask

   // Mostly ticks with occasional arrivals; full-range bursts once ids run out.
   task automatic test_random_mix(int n);
      logic [15:0] b;
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 9) == 0) b = 16'd0;
            else if (admitted >= PROCS) b = 16'($urandom);
            else b = 16'($urandom_range(1, 25));
            send_item(MODE_ARRIVAL, b);
         end else begin
            send_item(MODE_TICK, 16'($urandom));
         end
      end
   endtask

   // Hold the response side off while requests keep coming, to fill the block.
   task automatic test_backpressure;
      drain();
      hold_req = 1'b1;
      repeat (40) send_item(MODE_ARRIVAL, 16'($urandom));
      run_ticks(20);
   endtask

   initial begin
      quantum = QUANTUM_RESET;
      clock_now = '0;
      cur_pid = '0;
      cur_busy = 1'b0;
      slice_ticks = '0;
      preempted = 1'b0;
      admitted = 0;
      wait_total = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_quantum();
      test_quantum_extremes();
      set_quantum(8'($urandom_range(1, 8)));
      idle_on = 1'b1;
      test_random_mix(300);
      set_quantum(8'($urandom_range(2, 6)));
      test_random_mix(300);
      test_backpressure();
      set_quantum(8'($urandom_range(1, 255)));
      test_random_mix(250);
      // Final stretch runs at full rate on both sides.
      idle_on = 1'b0;
      set_quantum(8'd3);
      test_random_mix(240);
      drain();

      if (errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
